// File: design/tgc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgc_pkg - shared types and constants of the tilt gesture classifier
// CORDIC constants, angle rounding, gesture codes and control states.
// ----------------------------------------------------------------------------
package tgc_pkg;

   localparam int GUARD_BITS   = 24;
   localparam int CORDIC_ITERS = 20;
   localparam int ITER_W       = 5;
   localparam int ANG_FRAC     = 16;
   localparam int ANG_W        = 26;
   localparam int GAIN_W       = 31;
   localparam int GAIN_SHIFT   = 6;
   localparam logic [GAIN_W-1:0] GAIN_Q30 = 31'd1768195363;
   localparam logic signed [ANG_W-1:0] QUARTER_TURN = 26'sd5898240;

   localparam logic [1:0] CSR_DEADZONE  = 2'd0;
   localparam logic [1:0] CSR_MAX_ANGLE = 2'd1;
   localparam logic [1:0] CSR_THRESHOLD = 2'd2;
   localparam logic [1:0] CSR_CONFIRM   = 2'd3;

   localparam logic [3:0] GEST_CENTER        = 4'd0;
   localparam logic [3:0] GEST_LEFT          = 4'd1;
   localparam logic [3:0] GEST_RIGHT         = 4'd2;
   localparam logic [3:0] GEST_FORWARD       = 4'd3;
   localparam logic [3:0] GEST_BACK          = 4'd4;
   localparam logic [3:0] GEST_LEFT_FORWARD  = 4'd5;
   localparam logic [3:0] GEST_RIGHT_FORWARD = 4'd6;
   localparam logic [3:0] GEST_LEFT_BACK     = 4'd7;
   localparam logic [3:0] GEST_RIGHT_BACK    = 4'd8;

   localparam logic [7:0] AXIS_FULL = 8'd100;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AVG_GO,
      ST_AVG_WAIT,
      ST_ROLL_GO,
      ST_ROLL_WAIT,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_PITCH_GO,
      ST_PITCH_WAIT,
      ST_AXIS_GO,
      ST_AXIS_WAIT,
      ST_OUT
   } state_type;

   // atan(2^-i) in degrees, 16 fractional bits
   function automatic logic signed [ANG_W-1:0] cordic_atan(input logic [ITER_W-1:0] i);
      case (i)
         5'd0:  return 26'sd2949120;
         5'd1:  return 26'sd1740967;
         5'd2:  return 26'sd919879;
         5'd3:  return 26'sd466945;
         5'd4:  return 26'sd234379;
         5'd5:  return 26'sd117304;
         5'd6:  return 26'sd58666;
         5'd7:  return 26'sd29335;
         5'd8:  return 26'sd14668;
         5'd9:  return 26'sd7334;
         5'd10: return 26'sd3667;
         5'd11: return 26'sd1833;
         5'd12: return 26'sd917;
         5'd13: return 26'sd458;
         5'd14: return 26'sd229;
         5'd15: return 26'sd115;
         5'd16: return 26'sd57;
         5'd17: return 26'sd29;
         5'd18: return 26'sd14;
         5'd19: return 26'sd7;
         default: return 26'sd0;
      endcase
   endfunction

   // whole degrees, ties away from zero
   function automatic logic signed [9:0] round_deg(input logic signed [ANG_W-1:0] a);
      logic [ANG_W-1:0] m;
      logic [ANG_W-1:0] r;
      m = a[ANG_W-1] ? ANG_W'(-a) : ANG_W'(a);
      r = (m + (ANG_W'(1) << (ANG_FRAC - 1))) >> ANG_FRAC;
      return a[ANG_W-1] ? -10'(r) : 10'(r);
   endfunction

   function automatic logic [3:0] classify(input logic signed [7:0] r,
                                           input logic signed [7:0] p,
                                           input logic [6:0] th);
      logic signed [8:0] t;
      logic l, rt, f, b;
      t  = signed'({2'b00, th});
      l  = 9'(r) < -t;
      rt = 9'(r) > t;
      f  = 9'(p) > t;
      b  = 9'(p) < -t;
      if (l && f)  return GEST_LEFT_FORWARD;
      if (rt && f) return GEST_RIGHT_FORWARD;
      if (l && b)  return GEST_LEFT_BACK;
      if (rt && b) return GEST_RIGHT_BACK;
      if (l)       return GEST_LEFT;
      if (rt)      return GEST_RIGHT;
      if (f)       return GEST_FORWARD;
      if (b)       return GEST_BACK;
      return GEST_CENTER;
   endfunction

endpackage

// File: design/tgc_serial_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgc_serial_div - bit-serial restoring divider
// One quotient bit per cycle, dividend shifted out MSB first.
// ----------------------------------------------------------------------------
module tgc_serial_div #(
   parameter int DW = 17
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [7:0]    divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);
   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] work_ff, work_in;
   logic [7:0]    rem_ff, rem_in;
   logic [7:0]    dsr_ff, dsr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [8:0]    trial;
   logic          fits;

   assign trial = {rem_ff, work_ff[DW-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      work_in  = work_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         work_in  = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? 8'(trial - {1'b0, dsr_ff}) : trial[7:0];
         work_in  = {work_ff[DW-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == CW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = work_ff;
endmodule

// File: design/tgc_serial_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgc_serial_mul - bit-serial multiply by the CORDIC gain
// Multiplier consumed LSB first, one shift-add per cycle.
// ----------------------------------------------------------------------------
module tgc_serial_mul #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [SAMPLE_BITS-1:0]            operand,
   output logic                              done,
   output logic [SAMPLE_BITS+tgc_pkg::GAIN_W-1:0] product
);
   import tgc_pkg::*;

   localparam int PW = SAMPLE_BITS + GAIN_W;
   localparam int CW = $clog2(SAMPLE_BITS + 1);

   logic [SAMPLE_BITS-1:0] op_ff, op_in;
   logic [PW-1:0]          mc_ff, mc_in;
   logic [PW-1:0]          acc_ff, acc_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   always_comb begin
      op_in    = op_ff;
      mc_in    = mc_ff;
      acc_in   = acc_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         op_in    = operand;
         mc_in    = PW'(GAIN_Q30);
         acc_in   = '0;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (op_ff[0]) acc_in = acc_ff + mc_ff;
         mc_in    = mc_ff << 1;
         op_in    = op_ff >> 1;
         count_in = count_ff + 1'b1;
         if (count_ff == CW'(SAMPLE_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      mc_ff    <= mc_in;
      acc_ff   <= acc_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule

// File: design/tgc_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgc_cordic - iterative vectoring CORDIC
// One micro-rotation per cycle; quarter-turn pre-rotation for x < 0.
// ----------------------------------------------------------------------------
module tgc_cordic #(
   parameter int W = 44
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [W-1:0]                x_init,
   input  logic signed [W-1:0]                y_init,
   output logic                               done,
   output logic signed [tgc_pkg::ANG_W-1:0]   angle,
   output logic signed [W-1:0]                mag
);
   import tgc_pkg::*;

   logic signed [W-1:0]     x_ff, x_in, y_ff, y_in;
   logic signed [ANG_W-1:0] acc_ff, acc_in;
   logic [ITER_W-1:0]       iter_ff, iter_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic signed [W-1:0]     xs, ys;

   assign xs = x_ff >>> iter_ff;
   assign ys = y_ff >>> iter_ff;

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         iter_in = '0;
         acc_in  = '0;
         x_in    = x_init;
         y_in    = y_init;
         if (x_init == '0 && y_init == '0) begin
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
            if (x_init < 0) begin
               if (y_init >= 0) begin
                  acc_in = QUARTER_TURN;
                  x_in   = y_init;
                  y_in   = -x_init;
               end else begin
                  acc_in = -QUARTER_TURN;
                  x_in   = -y_init;
                  y_in   = x_init;
               end
            end
         end
      end else if (busy_ff) begin
         if (y_ff >= 0) begin
            x_in   = x_ff + ys;
            y_in   = y_ff - xs;
            acc_in = acc_ff + cordic_atan(iter_ff);
         end else begin
            x_in   = x_ff - ys;
            y_in   = y_ff + xs;
            acc_in = acc_ff - cordic_atan(iter_ff);
         end
         iter_in = iter_ff + 1'b1;
         if (iter_ff == ITER_W'(CORDIC_ITERS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      acc_ff  <= acc_in;
      iter_ff <= iter_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done  = done_ff;
   assign angle = acc_ff;
   assign mag   = x_ff;
endmodule

// File: design/tilt_gesture_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_gesture_classifier_top - accelerometer tilt gesture classifier
// Filters x/y/z samples, derives roll and pitch, maps them to axis values
// and reports a debounced nine-way gesture.
// ----------------------------------------------------------------------------
// One request at a time. A sample request runs through the shared bit-serial
// divider (three filter divisions, two axis divisions), the two 20-step CORDIC
// passes and the serial gain multiply; the first sample after reset skips the
// three filter divisions. A recenter request gives no response. The response
// sits in an output register, so the next request can be taken while it waits;
// only a new response waits for the old to go.
// ----------------------------------------------------------------------------
module tilt_gesture_classifier_top #(
   parameter int SAMPLE_BITS = 16,
   parameter int AVG_DIVISOR = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_opcode,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_x,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_y,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [9:0]             rsp_roll_angle,
   output logic signed [8:0]             rsp_pitch_angle,
   output logic signed [7:0]             rsp_roll_level,
   output logic signed [7:0]             rsp_pitch_level,
   output logic [3:0]                    rsp_gesture,
   input  logic                          csr_write,
   input  logic [1:0]                    csr_index,
   input  logic [7:0]                    csr_data
);
   import tgc_pkg::*;

   localparam int SB = SAMPLE_BITS;
   localparam int W  = SB + GUARD_BITS + 4;          // CORDIC datapath, growth headroom
   localparam int DW = (SB + 1 > 15) ? SB + 1 : 15;  // divider width
   localparam int PW = SB + GAIN_W;

   // configuration
   logic [6:0] deadzone_ff;
   logic [7:0] max_angle_ff;
   logic [6:0] threshold_ff;
   logic [3:0] confirm_ff;

   // state
   state_type state_ff, state_in;
   logic           loaded_ff;
   logic [1:0]     ch_ff;                             // filter channel / axis select
   logic signed [SB-1:0] samp_ff [3];                 // x, y, z
   logic signed [SB-1:0] avg_ff  [3];
   logic signed [W-1:0]  mag_ff;
   logic signed [8:0]    last_roll_ff, center_roll_ff;
   logic signed [7:0]    last_pitch_ff, center_pitch_ff;
   logic signed [7:0]    axis_ff [2];                 // roll, pitch
   logic [3:0]           stable_ff, cand_ff, run_ff;

   // output register
   logic                 rsp_valid_ff;
   logic signed [9:0]    o_roll_ff;
   logic signed [8:0]    o_pitch_ff;
   logic signed [7:0]    o_raxis_ff, o_paxis_ff;
   logic [3:0]           o_gest_ff;

   // unit handshakes
   logic div_start, mul_start, cor_start;
   logic div_done, mul_done, cor_done;
   logic [DW-1:0] div_dividend, div_quot;
   logic [7:0]    div_divisor;
   logic [PW-1:0] mul_prod;
   logic signed [W-1:0] cor_x, cor_y, cor_mag;
   logic signed [ANG_W-1:0] cor_angle;

   logic req_take;
   logic out_free;
   assign req_take = req_valid && !req_stall;
   assign out_free = !(rsp_valid_ff && rsp_stall);

   // filter delta for the current channel
   logic signed [SB:0] delta;
   logic [SB:0]        dmag;
   logic [SB:0]        dq;
   logic signed [SB:0] avg_next;
   assign delta    = (SB+1)'(samp_ff[ch_ff]) - (SB+1)'(avg_ff[ch_ff]);
   assign dmag     = delta[SB] ? (SB+1)'(-delta) : (SB+1)'(delta);
   assign dq       = div_quot[SB:0];
   assign avg_next = (SB+1)'(avg_ff[ch_ff]) + (delta[SB] ? -signed'(dq) : signed'(dq));

   // pitch operand: -x scaled by the CORDIC gain
   logic [SB-1:0]  ax_abs;
   logic [W-1:0]   px_mag;
   logic signed [W-1:0] px;
   assign ax_abs = avg_ff[0][SB-1] ? SB'(-avg_ff[0]) : SB'(avg_ff[0]);
   assign px_mag = W'(mul_prod[PW-1:GAIN_SHIFT]);
   assign px     = avg_ff[0][SB-1] ? signed'(px_mag) : -signed'(px_mag);

   // centred angles
   logic signed [9:0] rd, pd, cur_diff;
   logic [9:0]        cur_mag;
   logic              in_lin, sat;
   logic [16:0]       numer;
   logic [7:0]        lin_v;
   logic [7:0]        axis_v;
   assign rd       = 10'(last_roll_ff) - 10'(center_roll_ff);
   assign pd       = 10'(9'(last_pitch_ff) - 9'(center_pitch_ff));
   assign cur_diff = ch_ff[0] ? pd : rd;
   assign cur_mag  = cur_diff[9] ? 10'(-cur_diff) : 10'(cur_diff);
   assign in_lin   = (cur_mag > 10'(deadzone_ff)) && (cur_mag < 10'(max_angle_ff));
   assign sat      = (cur_mag > 10'(deadzone_ff)) && (cur_mag >= 10'(max_angle_ff));
   assign numer    = 17'(cur_mag - 10'(deadzone_ff)) * 17'd100;
   assign lin_v    = div_quot[7:0];
   assign axis_v   = sat ? AXIS_FULL : (in_lin ? lin_v : 8'd0);

   // debounce
   logic [3:0] cand_now, cand_nx, run_nx, stable_nx;
   assign cand_now = classify(axis_ff[0], axis_ff[1], threshold_ff);
   always_comb begin
      cand_nx   = cand_ff;
      run_nx    = run_ff;
      stable_nx = stable_ff;
      if (cand_now != cand_ff) begin
         cand_nx = cand_now;
         run_nx  = 4'd1;
      end else if (run_ff < confirm_ff) begin
         run_nx = run_ff + 1'b1;
      end
      if (run_nx >= confirm_ff) stable_nx = cand_nx;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:
            if (req_take && !req_opcode)
               state_in = loaded_ff ? ST_AVG_GO : ST_ROLL_GO;
         ST_AVG_GO:     state_in = ST_AVG_WAIT;
         ST_AVG_WAIT:
            if (div_done) state_in = (ch_ff == 2'd2) ? ST_ROLL_GO : ST_AVG_GO;
         ST_ROLL_GO:    state_in = ST_ROLL_WAIT;
         ST_ROLL_WAIT:  if (cor_done) state_in = ST_MUL_GO;
         ST_MUL_GO:     state_in = ST_MUL_WAIT;
         ST_MUL_WAIT:   if (mul_done) state_in = ST_PITCH_GO;
         ST_PITCH_GO:   state_in = ST_PITCH_WAIT;
         ST_PITCH_WAIT: if (cor_done) state_in = ST_AXIS_GO;
         ST_AXIS_GO:    state_in = ST_AXIS_WAIT;
         ST_AXIS_WAIT:
            if (div_done) state_in = ch_ff[0] ? ST_OUT : ST_AXIS_GO;
         ST_OUT:        if (out_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // unit controls
   always_comb begin
      req_stall    = 1'b1;
      div_start    = 1'b0;
      mul_start    = 1'b0;
      cor_start    = 1'b0;
      div_dividend = DW'(dmag);
      div_divisor  = 8'(AVG_DIVISOR);
      cor_x        = W'(signed'({avg_ff[2], {GUARD_BITS{1'b0}}}));
      cor_y        = W'(signed'({avg_ff[1], {GUARD_BITS{1'b0}}}));
      case (state_ff)
         ST_IDLE:     req_stall = 1'b0;
         ST_AVG_GO:   div_start = 1'b1;
         ST_ROLL_GO:  cor_start = 1'b1;
         ST_MUL_GO:   mul_start = 1'b1;
         ST_PITCH_GO: begin
            cor_start = 1'b1;
            cor_x     = mag_ff;
            cor_y     = px;
         end
         ST_AXIS_GO: begin
            div_start    = 1'b1;
            div_dividend = in_lin ? DW'(numer[14:0]) : '0;
            div_divisor  = in_lin ? 8'(max_angle_ff - 8'(deadzone_ff)) : 8'd1;
         end
         default: ;
      endcase
   end

   // datapath and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         loaded_ff       <= 1'b0;
         ch_ff           <= '0;
         avg_ff[0]       <= '0;
         avg_ff[1]       <= '0;
         avg_ff[2]       <= '0;
         last_roll_ff    <= '0;
         last_pitch_ff   <= '0;
         center_roll_ff  <= '0;
         center_pitch_ff <= '0;
         stable_ff       <= GEST_CENTER;
         cand_ff         <= GEST_CENTER;
         run_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         deadzone_ff     <= 7'd5;
         max_angle_ff    <= 8'd45;
         threshold_ff    <= 7'd1;
         confirm_ff      <= 4'd3;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            case (csr_index)
               CSR_DEADZONE:  deadzone_ff  <= csr_data[6:0];
               CSR_MAX_ANGLE: max_angle_ff <= csr_data;
               CSR_THRESHOLD: threshold_ff <= csr_data[6:0];
               CSR_CONFIRM:   confirm_ff   <= csr_data[3:0];
               default: ;
            endcase
         end
         // a new response may replace one that leaves at this edge
         if (state_ff == ST_OUT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               ch_ff <= '0;
               if (req_take) begin
                  if (req_opcode) begin
                     // recenter: only once the filter holds data
                     if (loaded_ff) begin
                        center_roll_ff  <= last_roll_ff;
                        center_pitch_ff <= last_pitch_ff;
                        stable_ff       <= GEST_CENTER;
                        cand_ff         <= GEST_CENTER;
                        run_ff          <= '0;
                     end
                  end else begin
                     samp_ff[0] <= req_accel_x;
                     samp_ff[1] <= req_accel_y;
                     samp_ff[2] <= req_accel_z;
                     if (!loaded_ff) begin
                        avg_ff[0] <= req_accel_x;
                        avg_ff[1] <= req_accel_y;
                        avg_ff[2] <= req_accel_z;
                        loaded_ff <= 1'b1;
                     end
                  end
               end
            end
            ST_AVG_WAIT:
               if (div_done) begin
                  avg_ff[ch_ff] <= avg_next[SB-1:0];
                  ch_ff         <= (ch_ff == 2'd2) ? 2'd0 : ch_ff + 1'b1;
               end
            ST_ROLL_WAIT:
               if (cor_done) begin
                  last_roll_ff <= 9'(round_deg(cor_angle));
                  mag_ff       <= cor_mag;
               end
            ST_PITCH_WAIT:
               if (cor_done) last_pitch_ff <= 8'(round_deg(cor_angle));
            ST_AXIS_WAIT:
               if (div_done) begin
                  axis_ff[ch_ff[0]] <= cur_diff[9] ? -signed'(axis_v) : signed'(axis_v);
                  ch_ff             <= ch_ff + 1'b1;
               end
            ST_OUT:
               if (out_free) begin
                  cand_ff      <= cand_nx;
                  run_ff       <= run_nx;
                  stable_ff    <= stable_nx;
                  o_roll_ff    <= rd;
                  o_pitch_ff   <= pd[8:0];
                  o_raxis_ff   <= axis_ff[0];
                  o_paxis_ff   <= axis_ff[1];
                  o_gest_ff    <= stable_nx;
               end
            default: ;
         endcase
      end
   end

   tgc_serial_div #(.DW(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   tgc_serial_mul #(.SAMPLE_BITS(SB)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .operand (ax_abs),
      .done    (mul_done),
      .product (mul_prod)
   );

   tgc_cordic #(.W(W)) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cor_start),
      .x_init (cor_x),
      .y_init (cor_y),
      .done   (cor_done),
      .angle  (cor_angle),
      .mag    (cor_mag)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_roll_angle  = o_roll_ff;
   assign rsp_pitch_angle = o_pitch_ff;
   assign rsp_roll_level  = o_raxis_ff;
   assign rsp_pitch_level = o_paxis_ff;
   assign rsp_gesture     = o_gest_ff;
endmodule

// File: design/tgc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgc_checker - port-level checks for the tilt gesture classifier
// Response range and handshake checks, bound to the top level.
// ----------------------------------------------------------------------------
module tgc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [8:0]             rsp_pitch_angle,
   input logic signed [7:0]             rsp_roll_level,
   input logic signed [7:0]             rsp_pitch_level,
   input logic [3:0]                    rsp_gesture
);
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_gesture))
      else $error("stalled response dropped or changed");

   a_gesture_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_gesture <= 4'd8)
      else $error("gesture code out of range");

   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_roll_level >= -8'sd100 && rsp_roll_level <= 8'sd100
                 && rsp_pitch_level >= -8'sd100 && rsp_pitch_level <= 8'sd100)
      else $error("axis value out of range");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pitch_angle >= -9'sd180 && rsp_pitch_angle <= 9'sd180)
      else $error("pitch out of range");
endmodule

bind tilt_gesture_classifier_top tgc_checker u_tgc_checker (.*);
